// File: rtl/core/tacc_pkg.sv
// ----------------------------------------------------------------------------
// Torque assist current controller package
// Shared widths, thresholds, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package tacc_pkg;

  localparam int TORQUE_W  = 16;
  localparam int POL_W     = 2;
  localparam int MAG_W     = TORQUE_W + 1;
  localparam int GAIN_W    = 16;
  localparam int CUR_W     = 16;
  localparam int LIM_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int DIGIT_W   = 4;
  localparam int MUL_STEPS = GAIN_W / DIGIT_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);
  localparam int PART_W    = MAG_W + DIGIT_W;
  localparam int ACC_W     = MAG_W + GAIN_W;

  localparam logic [MAG_W-1:0] ENTER_TORQUE = MAG_W'(256);
  localparam logic [MAG_W-1:0] EXIT_TORQUE  = MAG_W'(128);

  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_GAIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_STEP         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 3'd7;

  localparam logic OUT_STOP    = 1'b0;
  localparam logic OUT_CURRENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_LOAD,
    ST_GAIN,
    ST_MUL_CUR,
    ST_RESULT,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/core/tacc_if.sv
// ----------------------------------------------------------------------------
// Torque assist channel interfaces
// Valid/ready channels for the torque samples and for the drive results.
// ----------------------------------------------------------------------------
interface tacc_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tacc_pkg::TORQUE_W-1:0]    torque;
  logic signed [tacc_pkg::POL_W-1:0]       torque_polarity;

  modport source (output valid, output torque, output torque_polarity, input ready);
  modport sink   (input valid, input torque, input torque_polarity, output ready);
endinterface

interface tacc_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    output_kind;
  logic signed [tacc_pkg::CUR_W-1:0]       drive_current;
  logic        [tacc_pkg::GAIN_W-1:0]      applied_gain;
  logic                                    current_limited;
  logic                                    is_engaged;

  modport source (output valid, output output_kind, output drive_current,
                  output applied_gain, output current_limited, output is_engaged,
                  input ready);
  modport sink   (input valid, input output_kind, input drive_current,
                  input applied_gain, input current_limited, input is_engaged,
                  output ready);
endinterface

// File: rtl/core/torque_assist_current_controller_unit.sv
// ----------------------------------------------------------------------------
// Torque assist current controller
// Engagement hysteresis, gain selection and current command per torque sample.
// ----------------------------------------------------------------------------
// A torque sample transfers on the sample channel when valid and ready are
// both high; each sample yields exactly one result on the result channel.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data while the block is idle; the user must keep to this, as the
// block itself does not enforce it. Both products run through one shared
// multiplier that takes four gain bits per cycle. A sample that leaves the
// block stopped goes from ST_DECIDE straight to ST_FINISH, one in fixed-gain
// mode runs the current product and one in adaptive mode runs the load
// product, the gain update and the current product. A new sample is taken
// once the previous result has entered the output register.
// A registered output stage holds a finished result while the receiver
// stalls; the block still takes the next sample and waits with its result
// only if the output register is still full when that result is done.
// Synchronous reset disengages the block, clears the gain, empties the
// output stage and resets the state and the configuration registers.
// ----------------------------------------------------------------------------
module torque_assist_current_controller_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  tacc_sample_if.sink                          sample,
  tacc_result_if.source                        result,
  input  logic                                 cfg_write,
  input  logic [tacc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tacc_pkg::CFG_DAT_W-1:0]       cfg_data
);

  logic                          adaptive_enable;
  logic [tacc_pkg::GAIN_W-1:0]   fixed_gain;
  logic [tacc_pkg::GAIN_W-1:0]   base_gain;
  logic [tacc_pkg::GAIN_W-1:0]   load_gain;
  logic [tacc_pkg::GAIN_W-1:0]   max_gain;
  logic [tacc_pkg::GAIN_W-1:0]   gain_step;
  logic [tacc_pkg::LIM_W-1:0]    max_current;
  logic                          reverse_direction;

  tacc_pkg::state_t              state;
  tacc_pkg::state_t              state_next;

  logic                          engaged;
  logic [tacc_pkg::GAIN_W-1:0]   current_gain;

  logic [tacc_pkg::MAG_W-1:0]    mag;
  logic                          tneg;
  logic                          pneg;

  logic [tacc_pkg::GAIN_W-1:0]   mul_b;
  logic [tacc_pkg::ACC_W-1:0]    acc;
  logic [tacc_pkg::CNT_W-1:0]    cnt;

  logic                          res_kind;
  logic [tacc_pkg::CUR_W-1:0]    res_current;
  logic [tacc_pkg::GAIN_W-1:0]   res_gain;
  logic                          res_sat;

  logic                          out_valid;

  logic                          take_sample;
  logic                          load_out;
  logic                          mul_step;
  logic                          mul_last;
  logic                          stop_now;

  logic [tacc_pkg::PART_W-1:0]   partial;
  logic [tacc_pkg::PART_W:0]     mul_sum;
  logic [tacc_pkg::MAG_W-1:0]    in_mag;

  logic [25:0]                   target_sum;
  logic [tacc_pkg::GAIN_W-1:0]   target;
  logic [tacc_pkg::GAIN_W:0]     gain_up;
  logic signed [tacc_pkg::GAIN_W+1:0] gain_dn;
  logic [tacc_pkg::GAIN_W-1:0]   gain_new;

  logic [20:0]                   cmag;
  logic                          sat;
  logic [tacc_pkg::CUR_W-1:0]    cmag_lim;
  logic                          negative;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_enable   <= 1'b0;
      fixed_gain        <= '0;
      base_gain         <= '0;
      load_gain         <= '0;
      max_gain          <= '1;
      gain_step         <= '0;
      max_current       <= '0;
      reverse_direction <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tacc_pkg::REG_ADAPTIVE_ENABLE:   adaptive_enable   <= cfg_data[0];
        tacc_pkg::REG_FIXED_GAIN:        fixed_gain        <= cfg_data;
        tacc_pkg::REG_BASE_GAIN:         base_gain         <= cfg_data;
        tacc_pkg::REG_LOAD_GAIN:         load_gain         <= cfg_data;
        tacc_pkg::REG_MAX_GAIN:          max_gain          <= cfg_data;
        tacc_pkg::REG_GAIN_STEP:         gain_step         <= cfg_data;
        tacc_pkg::REG_MAX_CURRENT:       max_current       <= cfg_data[tacc_pkg::LIM_W-1:0];
        tacc_pkg::REG_REVERSE_DIRECTION: reverse_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      tacc_pkg::ST_IDLE: begin
        if (sample.valid) state_next = tacc_pkg::ST_DECIDE;
      end
      tacc_pkg::ST_DECIDE: begin
        if (stop_now)             state_next = tacc_pkg::ST_FINISH;
        else if (adaptive_enable) state_next = tacc_pkg::ST_MUL_LOAD;
        else                      state_next = tacc_pkg::ST_MUL_CUR;
      end
      tacc_pkg::ST_MUL_LOAD: begin
        if (mul_last) state_next = tacc_pkg::ST_GAIN;
      end
      tacc_pkg::ST_GAIN: state_next = tacc_pkg::ST_MUL_CUR;
      tacc_pkg::ST_MUL_CUR: begin
        if (mul_last) state_next = tacc_pkg::ST_RESULT;
      end
      tacc_pkg::ST_RESULT: state_next = tacc_pkg::ST_FINISH;
      tacc_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) state_next = tacc_pkg::ST_IDLE;
      end
      default: state_next = tacc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    take_sample = 1'b0;
    load_out    = 1'b0;
    mul_step    = 1'b0;
    case (state)
      tacc_pkg::ST_IDLE:     take_sample = sample.valid;
      tacc_pkg::ST_MUL_LOAD: mul_step    = 1'b1;
      tacc_pkg::ST_MUL_CUR:  mul_step    = 1'b1;
      tacc_pkg::ST_FINISH:   load_out    = !out_valid || result.ready;
      default: ;
    endcase
  end

  assign sample.ready = (state == tacc_pkg::ST_IDLE);
  assign mul_last     = (cnt == tacc_pkg::CNT_W'(tacc_pkg::MUL_STEPS - 1));
  assign stop_now     = engaged ? (mag <= tacc_pkg::EXIT_TORQUE)
                                : (mag <  tacc_pkg::ENTER_TORQUE);

  assign in_mag = sample.torque[tacc_pkg::TORQUE_W-1]
                  ? (tacc_pkg::MAG_W'(0) - {sample.torque[tacc_pkg::TORQUE_W-1],
                                            sample.torque})
                  : {1'b0, sample.torque};

  assign partial = mag * mul_b[tacc_pkg::DIGIT_W-1:0];
  assign mul_sum = {{(tacc_pkg::PART_W + 1 - tacc_pkg::MAG_W){1'b0}},
                    acc[tacc_pkg::ACC_W-1:tacc_pkg::GAIN_W]}
                   + {1'b0, partial};

  assign target_sum = {10'd0, base_gain} + {1'b0, acc[tacc_pkg::ACC_W-1:8]};
  assign target     = (target_sum > {10'd0, max_gain}) ? max_gain
                                                       : target_sum[tacc_pkg::GAIN_W-1:0];
  assign gain_up    = {1'b0, current_gain} + {1'b0, gain_step};
  assign gain_dn    = $signed({2'b00, current_gain}) - $signed({2'b00, gain_step});

  always_comb begin
    if (gain_step == '0 || current_gain == '0) begin
      gain_new = target;
    end else if ({1'b0, target} > gain_up) begin
      gain_new = gain_up[tacc_pkg::GAIN_W-1:0];
    end else if ($signed({2'b00, target}) < gain_dn) begin
      gain_new = gain_dn[tacc_pkg::GAIN_W-1:0];
    end else begin
      gain_new = target;
    end
  end

  assign cmag     = acc[tacc_pkg::ACC_W-1:12];
  assign sat      = cmag >= {6'd0, max_current};
  assign cmag_lim = sat ? {1'b0, max_current} : cmag[tacc_pkg::CUR_W-1:0];
  assign negative = (tneg ^ pneg) ^ reverse_direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tacc_pkg::ST_IDLE;
      engaged      <= 1'b0;
      current_gain <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tacc_pkg::ST_DECIDE) begin
        if (stop_now) begin
          engaged      <= 1'b0;
          current_gain <= '0;
        end else begin
          engaged <= 1'b1;
          if (!adaptive_enable) current_gain <= fixed_gain;
        end
      end else if (state == tacc_pkg::ST_GAIN) begin
        current_gain <= gain_new;
      end
      if (load_out)          out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Sample capture, shared digit-serial multiplier and result assembly.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      mag  <= in_mag;
      tneg <= sample.torque[tacc_pkg::TORQUE_W-1];
      pneg <= sample.torque_polarity[tacc_pkg::POL_W-1];
    end
    if (state == tacc_pkg::ST_DECIDE) begin
      acc   <= '0;
      cnt   <= '0;
      mul_b <= adaptive_enable ? load_gain : fixed_gain;
      if (stop_now) begin
        res_kind    <= tacc_pkg::OUT_STOP;
        res_current <= '0;
        res_gain    <= '0;
        res_sat     <= 1'b0;
      end
    end else if (state == tacc_pkg::ST_GAIN) begin
      acc   <= '0;
      cnt   <= '0;
      mul_b <= gain_new;
    end else if (mul_step) begin
      acc   <= tacc_pkg::ACC_W'({mul_sum, acc[tacc_pkg::GAIN_W-1:0]} >> tacc_pkg::DIGIT_W);
      mul_b <= mul_b >> tacc_pkg::DIGIT_W;
      cnt   <= cnt + 1'b1;
    end
    if (state == tacc_pkg::ST_RESULT) begin
      res_kind    <= tacc_pkg::OUT_CURRENT;
      res_current <= negative ? (tacc_pkg::CUR_W'(0) - cmag_lim) : cmag_lim;
      res_gain    <= current_gain;
      res_sat     <= sat;
    end
    if (load_out) begin
      result.output_kind     <= res_kind;
      result.drive_current   <= res_current;
      result.applied_gain    <= res_gain;
      result.current_limited <= res_sat;
      result.is_engaged      <= res_kind;
    end
  end

  assign result.valid = out_valid;

  a_gain_zero_when_disengaged: assert property (
    @(posedge clk) disable iff (rst) !engaged && state == tacc_pkg::ST_IDLE |-> current_gain == '0
  ) else $error("gain is not zero while disengaged");

  a_stop_result_zero: assert property (
    @(posedge clk) disable iff (rst)
    result.valid && result.output_kind == tacc_pkg::OUT_STOP |->
      result.drive_current == '0 && result.applied_gain == '0 &&
      !result.current_limited && !result.is_engaged
  ) else $error("stop result carries nonzero fields");

  a_gain_after_load_product: assert property (
    @(posedge clk) disable iff (rst)
    state == tacc_pkg::ST_GAIN |-> $past(state) == tacc_pkg::ST_MUL_LOAD && $past(mul_last)
  ) else $error("gain update without a finished load product");

  a_result_after_current_product: assert property (
    @(posedge clk) disable iff (rst)
    state == tacc_pkg::ST_RESULT |-> $past(state) == tacc_pkg::ST_MUL_CUR && $past(mul_last)
  ) else $error("result assembled without a finished current product");

endmodule

// File: verif/tacc_drive_checker.sv
// ----------------------------------------------------------------------------
// Torque assist drive checker
// Watches the sample, result and register write ports of the controller and
// keeps its own copy of the registers, engagement and gain. It predicts the
// drive command of every sample transfer and compares each result transfer,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tacc_drive_checker (
  input  logic                           clk,
  input  logic                           rst,
  tacc_sample_if                         sample_ch,
  tacc_result_if                         result_ch,
  input  logic                           cfg_write,
  input  logic [tacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tacc_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             in_flight
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                              kind;
    logic signed [tacc_pkg::CUR_W-1:0] current;
    logic [tacc_pkg::GAIN_W-1:0]       gain;
    logic                              saturated;
    logic                              engaged;
  } drive_t;

  logic                        adaptive_en;
  logic [tacc_pkg::GAIN_W-1:0] fixed_gain_r;
  logic [tacc_pkg::GAIN_W-1:0] base_gain_r;
  logic [tacc_pkg::GAIN_W-1:0] load_gain_r;
  logic [tacc_pkg::GAIN_W-1:0] max_gain_r;
  logic [tacc_pkg::GAIN_W-1:0] gain_step_r;
  logic [tacc_pkg::LIM_W-1:0]  max_current_r;
  logic                        reverse_dir;

  logic                        engaged_st;
  logic [tacc_pkg::GAIN_W-1:0] gain_st;

  drive_t drive_q[$];
  int     mismatches = 0;

  function automatic drive_t compute_drive(input logic [tacc_pkg::TORQUE_W-1:0] trq,
                                           input logic [tacc_pkg::POL_W-1:0] pol);
    drive_t d;
    logic   tneg;
    logic   pneg;
    logic   neg;
    longint mag;
    longint target;
    longint cur;
    longint stp;
    longint cmag;
    d    = '0;
    tneg = trq[tacc_pkg::TORQUE_W-1];
    pneg = pol[tacc_pkg::POL_W-1];
    mag  = tneg ? 65536 - longint'(trq) : longint'(trq);
    if (engaged_st) begin
      if (mag <= longint'(tacc_pkg::EXIT_TORQUE)) begin
        engaged_st = 1'b0;
        gain_st    = '0;
        return d;
      end
    end else if (mag < longint'(tacc_pkg::ENTER_TORQUE)) begin
      return d;
    end else begin
      engaged_st = 1'b1;
    end
    if (adaptive_en) begin
      target = longint'(base_gain_r) + ((mag * longint'(load_gain_r)) >> 8);
      if (target > longint'(max_gain_r)) target = longint'(max_gain_r);
      cur = longint'(gain_st);
      stp = longint'(gain_step_r);
      if (stp == 0 || cur == 0) gain_st = tacc_pkg::GAIN_W'(target);
      else if (target > cur + stp) gain_st = tacc_pkg::GAIN_W'(cur + stp);
      else if (target < cur - stp) gain_st = tacc_pkg::GAIN_W'(cur - stp);
      else gain_st = tacc_pkg::GAIN_W'(target);
    end else begin
      gain_st = fixed_gain_r;
    end
    cmag        = (mag * longint'(gain_st)) >> 12;
    d.saturated = cmag >= longint'(max_current_r);
    if (cmag > longint'(max_current_r)) cmag = longint'(max_current_r);
    neg       = (tneg ^ pneg) ^ reverse_dir;
    d.kind    = tacc_pkg::OUT_CURRENT;
    d.current = tacc_pkg::CUR_W'(neg ? -cmag : cmag);
    d.gain    = gain_st;
    d.engaged = 1'b1;
    return d;
  endfunction

  always @(posedge clk) begin : monitor
    drive_t exp_d;
    drive_t got_d;
    if (rst) begin
      adaptive_en   = 1'b0;
      fixed_gain_r  = '0;
      base_gain_r   = '0;
      load_gain_r   = '0;
      max_gain_r    = '1;
      gain_step_r   = '0;
      max_current_r = '0;
      reverse_dir   = 1'b0;
      engaged_st    = 1'b0;
      gain_st       = '0;
      drive_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tacc_pkg::REG_ADAPTIVE_ENABLE:   adaptive_en   = cfg_data[0];
          tacc_pkg::REG_FIXED_GAIN:        fixed_gain_r  = cfg_data;
          tacc_pkg::REG_BASE_GAIN:         base_gain_r   = cfg_data;
          tacc_pkg::REG_LOAD_GAIN:         load_gain_r   = cfg_data;
          tacc_pkg::REG_MAX_GAIN:          max_gain_r    = cfg_data;
          tacc_pkg::REG_GAIN_STEP:         gain_step_r   = cfg_data;
          tacc_pkg::REG_MAX_CURRENT:       max_current_r = cfg_data[tacc_pkg::LIM_W-1:0];
          tacc_pkg::REG_REVERSE_DIRECTION: reverse_dir   = cfg_data[0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        drive_q.push_back(compute_drive(sample_ch.torque, sample_ch.torque_polarity));
      end
      if (result_ch.valid && result_ch.ready) begin
        got_d.kind      = result_ch.output_kind;
        got_d.current   = result_ch.drive_current;
        got_d.gain      = result_ch.applied_gain;
        got_d.saturated = result_ch.current_limited;
        got_d.engaged   = result_ch.is_engaged;
        if (drive_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result transfer with no prediction waiting: kind=%0d cur=%0d",
                     $realtime, got_d.kind, got_d.current);
          end
          mismatches++;
        end else begin
          exp_d = drive_q.pop_front();
          if (got_d !== exp_d) begin
            if (mismatches < 10) begin
              $display("%0t: drive mismatch: expected kind=%0d cur=%0d gain=%0d sat=%0d eng=%0d",
                       $realtime, exp_d.kind, exp_d.current, exp_d.gain,
                       exp_d.saturated, exp_d.engaged);
              $display("%0t:                 actual   kind=%0d cur=%0d gain=%0d sat=%0d eng=%0d",
                       $realtime, got_d.kind, got_d.current, got_d.gain,
                       got_d.saturated, got_d.engaged);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    in_flight  <= drive_q.size();
  end

endmodule

// File: verif/torque_assist_current_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Torque assist current controller testbench
// Drives torque samples through a directed opening and then random phases of
// press and release sequences mixed with noise, each phase under its own
// register settings, with random idling on both channels. A checker beside
// the block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module torque_assist_current_controller_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [tacc_pkg::POL_W-1:0] POL_ZERO = 2'b00;
  localparam logic [tacc_pkg::POL_W-1:0] POL_POS  = 2'b01;
  localparam logic [tacc_pkg::POL_W-1:0] POL_NEG2 = 2'b10;
  localparam logic [tacc_pkg::POL_W-1:0] POL_NEG  = 2'b11;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [tacc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tacc_pkg::CFG_DAT_W-1:0] cfg_data;
  int                             fail_count;
  int                             in_flight;
  int                             cycle_count = 0;
  bit                             no_idle = 1'b0;
  logic [tacc_pkg::CFG_DAT_W-1:0] reg_image [8];

  tacc_sample_if sample_ch ();
  tacc_result_if result_ch ();

  torque_assist_current_controller_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tacc_drive_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("torque_assist_current_controller_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [tacc_pkg::TORQUE_W-1:0] to_torque(input int mag, input bit neg);
    return neg ? tacc_pkg::TORQUE_W'(-mag) : tacc_pkg::TORQUE_W'(mag);
  endfunction

  function automatic logic [tacc_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return tacc_pkg::GAIN_W'($urandom_range(0, 16'h2000));
      default: return tacc_pkg::GAIN_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [tacc_pkg::TORQUE_W-1:0] trq,
                             input logic [tacc_pkg::POL_W-1:0] pol);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.torque          <= trq;
    sample_ch.torque_polarity <= pol;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= tacc_pkg::CFG_IDX_W'(i);
      cfg_data  <= reg_image[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_drain
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int mag;
    int thr [7];
    bit press;
    rst                       <= 1'b1;
    sample_ch.valid           <= 1'b0;
    sample_ch.torque          <= '0;
    sample_ch.torque_polarity <= '0;
    cfg_write                 <= 1'b0;
    cfg_index                 <= '0;
    cfg_data                  <= '0;
    thr = '{0, int'(tacc_pkg::EXIT_TORQUE) - 1, int'(tacc_pkg::EXIT_TORQUE),
            int'(tacc_pkg::EXIT_TORQUE) + 1, int'(tacc_pkg::ENTER_TORQUE) - 1,
            int'(tacc_pkg::ENTER_TORQUE), int'(tacc_pkg::ENTER_TORQUE) + 1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: fixed mode with zero gain and zero current limit.
    send_sample(to_torque(0, 1'b0), POL_POS);
    send_sample(to_torque(256, 1'b0), POL_ZERO);
    settle();

    reg_image[tacc_pkg::REG_ADAPTIVE_ENABLE]   = 16'h0000;
    reg_image[tacc_pkg::REG_FIXED_GAIN]        = 16'h1000;
    reg_image[tacc_pkg::REG_BASE_GAIN]         = 16'h0000;
    reg_image[tacc_pkg::REG_LOAD_GAIN]         = 16'h0000;
    reg_image[tacc_pkg::REG_MAX_GAIN]          = 16'hFFFF;
    reg_image[tacc_pkg::REG_GAIN_STEP]         = 16'h0000;
    reg_image[tacc_pkg::REG_MAX_CURRENT]       = 16'h7FFF;
    reg_image[tacc_pkg::REG_REVERSE_DIRECTION] = 16'h0000;
    write_regs();
    send_sample(to_torque(0, 1'b0), POL_POS);
    send_sample(to_torque(255, 1'b0), POL_POS);
    send_sample(to_torque(256, 1'b0), POL_POS);
    send_sample(to_torque(129, 1'b0), POL_POS);
    send_sample(to_torque(128, 1'b0), POL_POS);
    send_sample(to_torque(300, 1'b0), POL_ZERO);
    send_sample(to_torque(300, 1'b1), POL_POS);
    send_sample(to_torque(300, 1'b0), POL_NEG);
    send_sample(to_torque(300, 1'b0), POL_NEG2);
    send_sample(to_torque(32767, 1'b0), POL_POS);
    send_sample(to_torque(32768, 1'b1), POL_NEG);
    send_sample(to_torque(1, 1'b1), POL_POS);
    settle();

    reg_image[tacc_pkg::REG_ADAPTIVE_ENABLE]   = 16'h0001;
    reg_image[tacc_pkg::REG_BASE_GAIN]         = 16'h0800;
    reg_image[tacc_pkg::REG_LOAD_GAIN]         = 16'h0100;
    reg_image[tacc_pkg::REG_MAX_GAIN]          = 16'h3000;
    reg_image[tacc_pkg::REG_GAIN_STEP]         = 16'h0100;
    reg_image[tacc_pkg::REG_MAX_CURRENT]       = 16'h0400;
    reg_image[tacc_pkg::REG_REVERSE_DIRECTION] = 16'h0001;
    write_regs();
    send_sample(to_torque(256, 1'b0), POL_POS);
    send_sample(to_torque(2000, 1'b1), POL_POS);
    send_sample(to_torque(32767, 1'b0), POL_NEG);
    send_sample(to_torque(32767, 1'b0), POL_ZERO);
    send_sample(to_torque(300, 1'b1), POL_NEG2);
    send_sample(to_torque(129, 1'b0), POL_POS);
    send_sample(to_torque(100, 1'b0), POL_POS);
    send_sample(to_torque(400, 1'b0), POL_POS);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        for (int i = 0; i < 8; i++) reg_image[i] = 16'hFFFF;
      end else if (p == 1) begin
        for (int i = 0; i < 8; i++) reg_image[i] = 16'h0000;
        reg_image[tacc_pkg::REG_ADAPTIVE_ENABLE] = 16'hFFFE;
      end else begin
        reg_image[tacc_pkg::REG_ADAPTIVE_ENABLE] = tacc_pkg::CFG_DAT_W'($urandom);
        reg_image[tacc_pkg::REG_FIXED_GAIN]      = pick_gain();
        reg_image[tacc_pkg::REG_BASE_GAIN]       = pick_gain();
        reg_image[tacc_pkg::REG_LOAD_GAIN]       = pick_gain();
        reg_image[tacc_pkg::REG_MAX_GAIN]        = pick_gain();
        reg_image[tacc_pkg::REG_GAIN_STEP]       =
          ($urandom_range(0, 2) == 0) ? pick_gain() :
          tacc_pkg::CFG_DAT_W'($urandom_range(1, 16'h0400));
        reg_image[tacc_pkg::REG_MAX_CURRENT]     =
          ($urandom_range(0, 3) == 0) ? pick_gain() :
          tacc_pkg::CFG_DAT_W'($urandom_range(16'h0100, 16'h7FFF));
        reg_image[tacc_pkg::REG_REVERSE_DIRECTION] = tacc_pkg::CFG_DAT_W'($urandom);
      end
      write_regs();
      no_idle = (p % 4 == 3);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        len   = $urandom_range(1, 12);
        press = $urandom_range(0, 9) < 7;
        for (int k = 0; k < len; k++) begin
          if (press) begin
            if (k == len - 1) begin
              mag = $urandom_range(0, int'(tacc_pkg::EXIT_TORQUE));
            end else if (k == 0) begin
              mag = $urandom_range(int'(tacc_pkg::ENTER_TORQUE), 2000);
            end else if ($urandom_range(0, 1)) begin
              mag = $urandom_range(int'(tacc_pkg::EXIT_TORQUE) + 1, 1000);
            end else begin
              mag = $urandom_range(int'(tacc_pkg::EXIT_TORQUE) + 1, 32768);
            end
          end else begin
            case ($urandom_range(0, 3))
              0:       mag = $urandom_range(0, 600);
              1:       mag = thr[$urandom_range(0, 6)];
              2:       mag = $urandom_range(0, 32768);
              default: mag = $urandom_range(0, 1) ? 32768 : 32767;
            endcase
          end
          send_sample(to_torque(mag, 1'($urandom_range(0, 1))),
                      tacc_pkg::POL_W'($urandom_range(0, 3)));
          n++;
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("torque_assist_current_controller_unit_tb: done, clean");
    end else begin
      $display("torque_assist_current_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: torque_assist_current_controller_unit.f
rtl/core/tacc_pkg.sv
rtl/core/tacc_if.sv
rtl/core/torque_assist_current_controller_unit.sv
verif/tacc_drive_checker.sv
verif/torque_assist_current_controller_unit_tb.sv
